[hw/rtl/rotation_matrix_to_quaternion_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the rotation matrix to quaternion block.
// Defining ASSERT_OFF compiles every check away.
// ---------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`ifndef ASSERT_OFF
`define RMQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define RMQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define RMQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define RMQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[hw/rtl/rmq_pkg.sv]
// ---------------------------------------------------------------------------
// rmq_pkg
// Field widths, selector codes and saturation helpers shared by the block.
// ---------------------------------------------------------------------------
package rmq_pkg;

  localparam int FIELD_W = 18;
  // Quotient magnitudes never exceed 2^17, so 18 quotient bits suffice.
  localparam int QUO_W = 18;

  localparam logic signed [FIELD_W-1:0] FIELD_MAX = 18'sh1FFFF;
  localparam logic signed [FIELD_W-1:0] FIELD_MIN = 18'sh20000;

  typedef logic [1:0] sel_t;
  localparam sel_t SEL_X = 2'd0;
  localparam sel_t SEL_Y = 2'd1;
  localparam sel_t SEL_Z = 2'd2;
  localparam sel_t SEL_W = 2'd3;

  // Signed, saturated component from a quotient magnitude and its sign.
  function automatic logic signed [FIELD_W-1:0] sat_quot(input logic [QUO_W-1:0] q,
                                                         input logic neg);
    logic [FIELD_W-1:0] r;
    if (neg) begin
      r = FIELD_W'(~q + 1'b1);
    end else if (q[QUO_W-1]) begin
      r = FIELD_MAX;
    end else begin
      r = FIELD_W'(q);
    end
    return $signed(r);
  endfunction

endpackage

[hw/rtl/rmq_sqrt_cell.sv]
// ---------------------------------------------------------------------------
// rmq_sqrt_cell
// One digit of a restoring square root: takes two radicand bits, yields one
// root bit, and hands the partial remainder and root to the next cell.
// ---------------------------------------------------------------------------
module rmq_sqrt_cell #(
  parameter int RW  = 18,
  parameter int XPW = 36
) (
  input  logic            clk,
  input  logic            en,
  input  logic [XPW-1:0]  x_in,
  input  logic [RW+1:0]   rem_in,
  input  logic [RW-1:0]   root_in,
  output logic [XPW-1:0]  x_r,
  output logic [RW+1:0]   rem_r,
  output logic [RW-1:0]   root_r
);

  logic [RW+1:0]  rem_sh;
  logic [RW+1:0]  trial;
  logic           ge;
  logic [XPW-1:0] x_nxt;
  logic [RW+1:0]  rem_nxt;
  logic [RW-1:0]  root_nxt;

  // The partial remainder stays below 2^RW, so the dropped top bits are zero.
  assign rem_sh   = {rem_in[RW-1:0], x_in[XPW-1 -: 2]};
  assign trial    = {root_in, 2'b01};
  assign ge       = (rem_sh >= trial);
  assign rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
  assign root_nxt = {root_in[RW-2:0], ge};
  assign x_nxt    = {x_in[XPW-3:0], 2'b00};

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

endmodule

[hw/rtl/rmq_div_cell.sv]
// ---------------------------------------------------------------------------
// rmq_div_cell
// One quotient bit of a restoring divider: tries the divisor shifted to this
// cell's bit position and passes the remainder and quotient along.
// ---------------------------------------------------------------------------
module rmq_div_cell #(
  parameter int NW = 35,
  parameter int DW = 19,
  parameter int QB = 18,
  parameter int SH = 17
) (
  input  logic           clk,
  input  logic           en,
  input  logic [NW-1:0]  rem_in,
  input  logic [QB-1:0]  q_in,
  input  logic           neg_in,
  input  logic [DW-1:0]  den_in,
  output logic [NW-1:0]  rem_r,
  output logic [QB-1:0]  q_r,
  output logic           neg_r,
  output logic [DW-1:0]  den_r
);

  localparam int CMPW = (NW > DW + QB) ? NW : DW + QB;

  logic [CMPW-1:0] remx;
  logic [CMPW-1:0] trial;
  logic            ge;
  logic [NW-1:0]   rem_nxt;
  logic [QB-1:0]   q_nxt;

  assign remx  = CMPW'(rem_in);
  assign trial = CMPW'(den_in) << SH;
  assign ge    = (remx >= trial);

  always_comb begin
    rem_nxt = ge ? NW'(remx - trial) : rem_in;
    q_nxt   = q_in;
    if (ge) begin
      q_nxt[SH] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      neg_r <= neg_in;
      den_r <= den_in;
    end
  end

endmodule

[hw/rtl/rotation_matrix_to_quaternion.sv]
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a Q2.16 rotation matrix to a unit quaternion.
// Stages: one selection stage, one square-root cell per root bit (RW = 18
//   at the default), one divisor stage, 18 divider cells per lane and the
//   output register.
// Throughput: one beat per cycle; the whole row of cells advances together
//   whenever the output register is empty or being taken.
// Reset clears only the valid bits of the stages and the output.
// ---------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_defines.svh"

module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r1c1,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r1c2,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r1c3,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r2c1,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r2c2,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r2c3,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r3c1,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r3c2,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r3c3,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [rmq_pkg::FIELD_W-1:0] out_quat_x,
  output logic signed [rmq_pkg::FIELD_W-1:0] out_quat_y,
  output logic signed [rmq_pkg::FIELD_W-1:0] out_quat_z,
  output logic signed [rmq_pkg::FIELD_W-1:0] out_quat_w,
  output rmq_pkg::sel_t out_largest_sel
);

  localparam int FW  = rmq_pkg::FIELD_W;
  localparam int QB  = rmq_pkg::QUO_W;
  localparam int CW  = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 2;
  localparam int XW  = CW - 1 + FRAC_BITS;
  localparam int RW  = (XW + 1) / 2;
  localparam int XPW = 2 * RW;
  localparam int VW  = RW - 1;
  localparam int DW  = RW + 1;
  localparam int SW  = FW + 1;
  localparam int NW  = SW + FRAC_BITS;

  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign out_valid = out_valid_r;

  // Candidate selection.
  logic signed [CW-1:0] one_c;
  logic signed [CW-1:0] e11, e22, e33;
  logic signed [CW-1:0] cand0, cand1, cand2, cand3, best;
  rmq_pkg::sel_t        sel;
  logic signed [SW-1:0] p_a, p_b, p_c, p_d, p_e, p_f;
  logic signed [SW-1:0] p_sel [3];

  assign one_c = {{(CW - 1 - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  assign e11   = CW'(in_r1c1);
  assign e22   = CW'(in_r2c2);
  assign e33   = CW'(in_r3c3);
  assign cand0 = e11 - e22 - e33 + one_c;
  assign cand1 = -e11 + e22 - e33 + one_c;
  assign cand2 = -e11 - e22 + e33 + one_c;
  assign cand3 = e11 + e22 + e33 + one_c;

  assign p_a = SW'(in_r1c2) + SW'(in_r2c1);
  assign p_b = SW'(in_r3c1) + SW'(in_r1c3);
  assign p_c = SW'(in_r2c3) - SW'(in_r3c2);
  assign p_d = SW'(in_r2c3) + SW'(in_r3c2);
  assign p_e = SW'(in_r3c1) - SW'(in_r1c3);
  assign p_f = SW'(in_r1c2) - SW'(in_r2c1);

  always_comb begin
    best = cand0;
    sel  = rmq_pkg::SEL_X;
    if (cand1 > best) begin
      best = cand1;
      sel  = rmq_pkg::SEL_Y;
    end
    if (cand2 > best) begin
      best = cand2;
      sel  = rmq_pkg::SEL_Z;
    end
    if (cand3 > best) begin
      best = cand3;
      sel  = rmq_pkg::SEL_W;
    end
  end

  // The three divided components, in x, y, z, w order with the chosen one skipped.
  always_comb begin
    case (sel)
      rmq_pkg::SEL_X: begin
        p_sel[0] = p_a; p_sel[1] = p_b; p_sel[2] = p_c;
      end
      rmq_pkg::SEL_Y: begin
        p_sel[0] = p_a; p_sel[1] = p_d; p_sel[2] = p_e;
      end
      rmq_pkg::SEL_Z: begin
        p_sel[0] = p_b; p_sel[1] = p_d; p_sel[2] = p_f;
      end
      default: begin
        p_sel[0] = p_c; p_sel[1] = p_e; p_sel[2] = p_f;
      end
    endcase
  end

  logic                 s0_valid_r;
  logic [CW-2:0]        s0_e_r;
  rmq_pkg::sel_t        s0_sel_r;
  logic signed [SW-1:0] s0_p_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_e_r   <= best[CW-2:0];
      s0_sel_r <= sel;
      for (int l = 0; l < 3; l++) begin
        s0_p_r[l] <= p_sel[l];
      end
    end
  end

  // Square-root row.
  logic [XPW-1:0] sq_x    [RW+1];
  logic [RW+1:0]  sq_rem  [RW+1];
  logic [RW-1:0]  sq_root [RW+1];

  assign sq_x[0]    = XPW'({s0_e_r, {FRAC_BITS{1'b0}}});
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    rmq_sqrt_cell #(.RW(RW), .XPW(XPW)) u_cell (
      .clk     (clk),
      .en      (adv),
      .x_in    (sq_x[k]),
      .rem_in  (sq_rem[k]),
      .root_in (sq_root[k]),
      .x_r     (sq_x[k+1]),
      .rem_r   (sq_rem[k+1]),
      .root_r  (sq_root[k+1])
    );
  end

  logic                 sq_vld_r [RW];
  rmq_pkg::sel_t        sq_sel_r [RW];
  logic signed [SW-1:0] sq_p_r   [RW][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < RW; k++) begin
        sq_vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      sq_vld_r[0] <= s0_valid_r;
      for (int k = 1; k < RW; k++) begin
        sq_vld_r[k] <= sq_vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_sel_r[0] <= s0_sel_r;
      for (int l = 0; l < 3; l++) begin
        sq_p_r[0][l] <= s0_p_r[l];
      end
      for (int k = 1; k < RW; k++) begin
        sq_sel_r[k] <= sq_sel_r[k-1];
        for (int l = 0; l < 3; l++) begin
          sq_p_r[k][l] <= sq_p_r[k-1][l];
        end
      end
    end
  end

  // Divisor stage: v = root / 2, divisor 4v, numerators as sign and magnitude.
  logic [VW-1:0] v_c;
  logic [SW-1:0] mag_c [3];

  assign v_c = sq_root[RW][RW-1:1];
  for (genvar l = 0; l < 3; l++) begin : g_mag
    assign mag_c[l] = sq_p_r[RW-1][l][SW-1] ? (~sq_p_r[RW-1][l] + 1'b1) : sq_p_r[RW-1][l];
  end

  logic          s1_valid_r;
  logic [VW-1:0] s1_v_r;
  rmq_pkg::sel_t s1_sel_r;
  logic [DW-1:0] s1_den_r;
  logic [NW-1:0] s1_rem_r [3];
  logic          s1_neg_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= sq_vld_r[RW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_v_r   <= v_c;
      s1_sel_r <= sq_sel_r[RW-1];
      s1_den_r <= {v_c, 2'b00};
      for (int l = 0; l < 3; l++) begin
        s1_rem_r[l] <= {mag_c[l], {FRAC_BITS{1'b0}}};
        s1_neg_r[l] <= sq_p_r[RW-1][l][SW-1];
      end
    end
  end

  // Divider rows, one lane per divided component.
  logic [NW-1:0] dv_rem [3][QB+1];
  logic [QB-1:0] dv_q   [3][QB+1];
  logic          dv_neg [3][QB+1];
  logic [DW-1:0] dv_den [3][QB+1];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign dv_rem[l][0] = s1_rem_r[l];
    assign dv_q[l][0]   = '0;
    assign dv_neg[l][0] = s1_neg_r[l];
    assign dv_den[l][0] = s1_den_r;
    for (genvar k = 0; k < QB; k++) begin : g_div
      rmq_div_cell #(.NW(NW), .DW(DW), .QB(QB), .SH(QB - 1 - k)) u_cell (
        .clk    (clk),
        .en     (adv),
        .rem_in (dv_rem[l][k]),
        .q_in   (dv_q[l][k]),
        .neg_in (dv_neg[l][k]),
        .den_in (dv_den[l][k]),
        .rem_r  (dv_rem[l][k+1]),
        .q_r    (dv_q[l][k+1]),
        .neg_r  (dv_neg[l][k+1]),
        .den_r  (dv_den[l][k+1])
      );
    end
  end

  logic          dv_vld_r [QB];
  rmq_pkg::sel_t dv_sel_r [QB];
  logic [VW-1:0] dv_v_r   [QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QB; k++) begin
        dv_vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      dv_vld_r[0] <= s1_valid_r;
      for (int k = 1; k < QB; k++) begin
        dv_vld_r[k] <= dv_vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_sel_r[0] <= s1_sel_r;
      dv_v_r[0]   <= s1_v_r;
      for (int k = 1; k < QB; k++) begin
        dv_sel_r[k] <= dv_sel_r[k-1];
        dv_v_r[k]   <= dv_v_r[k-1];
      end
    end
  end

  // Output assembly.
  logic signed [FW-1:0] comp_c [3];
  logic signed [FW-1:0] v_sat_c;
  logic signed [FW-1:0] qx_nxt, qy_nxt, qz_nxt, qw_nxt;
  logic signed [FW-1:0] quat_x_r, quat_y_r, quat_z_r, quat_w_r;
  rmq_pkg::sel_t        sel_r;

  for (genvar l = 0; l < 3; l++) begin : g_sat
    assign comp_c[l] = rmq_pkg::sat_quot(dv_q[l][QB], dv_neg[l][QB]);
  end

  assign v_sat_c = (32'(dv_v_r[QB-1]) > 32'($unsigned(rmq_pkg::FIELD_MAX))) ?
                   rmq_pkg::FIELD_MAX : $signed(FW'(dv_v_r[QB-1]));

  always_comb begin
    case (dv_sel_r[QB-1])
      rmq_pkg::SEL_X: begin
        qx_nxt = v_sat_c; qy_nxt = comp_c[0]; qz_nxt = comp_c[1]; qw_nxt = comp_c[2];
      end
      rmq_pkg::SEL_Y: begin
        qx_nxt = comp_c[0]; qy_nxt = v_sat_c; qz_nxt = comp_c[1]; qw_nxt = comp_c[2];
      end
      rmq_pkg::SEL_Z: begin
        qx_nxt = comp_c[0]; qy_nxt = comp_c[1]; qz_nxt = v_sat_c; qw_nxt = comp_c[2];
      end
      default: begin
        qx_nxt = comp_c[0]; qy_nxt = comp_c[1]; qz_nxt = comp_c[2]; qw_nxt = v_sat_c;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_vld_r[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quat_x_r <= qx_nxt;
      quat_y_r <= qy_nxt;
      quat_z_r <= qz_nxt;
      quat_w_r <= qw_nxt;
      sel_r    <= dv_sel_r[QB-1];
    end
  end

  assign out_quat_x      = quat_x_r;
  assign out_quat_y      = quat_y_r;
  assign out_quat_z      = quat_z_r;
  assign out_quat_w      = quat_w_r;
  assign out_largest_sel = sel_r;

  // The component picked as largest is never negative.
  logic chosen_neg;
  always_comb begin
    case (sel_r)
      rmq_pkg::SEL_X: chosen_neg = quat_x_r[FW-1];
      rmq_pkg::SEL_Y: chosen_neg = quat_y_r[FW-1];
      rmq_pkg::SEL_Z: chosen_neg = quat_z_r[FW-1];
      default:        chosen_neg = quat_w_r[FW-1];
    endcase
  end

  `RMQ_ASSERT_NEXT(a_largest_ge_one, clk, rst_n, in_valid && in_ready, !s0_valid_r || (s0_e_r >= one_c[CW-2:0]), "largest candidate below one")
  `RMQ_ASSERT_IMPL(a_sqrt_exact, clk, rst_n, sq_vld_r[RW-1], (sq_x[RW] == '0) && (64'(sq_rem[RW]) <= 64'({sq_root[RW], 1'b0})), "square-root remainder out of bound")
  `RMQ_ASSERT_IMPL(a_div_rem, clk, rst_n, dv_vld_r[QB-1], (64'(dv_rem[0][QB]) < 64'(dv_den[0][QB])) && (64'(dv_rem[1][QB]) < 64'(dv_den[1][QB])) && (64'(dv_rem[2][QB]) < 64'(dv_den[2][QB])) && (dv_den[0][QB] == {dv_v_r[QB-1], 2'b00}) && (dv_den[1][QB] == dv_den[0][QB]) && (dv_den[2][QB] == dv_den[0][QB]), "divider remainder or divisor mismatch")
  `RMQ_ASSERT_IMPL(a_chosen_pos, clk, rst_n, out_valid_r, !chosen_neg, "chosen component negative")

endmodule

[tb/rmq_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmq_checker
// Watches both channels of the matrix to quaternion block, predicts each
// quaternion from the accepted matrix and compares every field in order.
// ---------------------------------------------------------------------------
module rmq_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r1c1,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r1c2,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r1c3,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r2c1,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r2c2,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r2c3,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r3c1,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r3c2,
  input  logic signed [rmq_pkg::FIELD_W-1:0] in_r3c3,
  input  logic out_valid,
  input  logic out_ready,
  input  logic signed [rmq_pkg::FIELD_W-1:0] out_quat_x,
  input  logic signed [rmq_pkg::FIELD_W-1:0] out_quat_y,
  input  logic signed [rmq_pkg::FIELD_W-1:0] out_quat_z,
  input  logic signed [rmq_pkg::FIELD_W-1:0] out_quat_w,
  input  rmq_pkg::sel_t out_largest_sel,
  output int   fail_count,
  output int   pending
);
  import rmq_pkg::*;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x, y, z, w;
    sel_t sel;
  } quat_t;

  quat_t quat_q[$];

  assign pending = quat_q.size();

  function automatic longint unsigned int_sqrt(longint unsigned a);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > a) bitv >>= 2;
    while (bitv != 0) begin
      if (a >= res + bitv) begin
        a -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [FIELD_W-1:0] clamp(longint v);
    if (v > 131071) return 18'sh1FFFF;
    if (v < -131072) return 18'sh20000;
    return v[FIELD_W-1:0];
  endfunction

  // Pair term times 2^FRAC_BITS over den, truncated toward zero.
  function automatic logic signed [FIELD_W-1:0] pair_quot(longint s, longint den);
    longint mag, qv;
    mag = (s < 0) ? -s : s;
    qv = (mag <<< FRAC_BITS) / den;
    return clamp((s < 0) ? -qv : qv);
  endfunction

  function automatic quat_t predict_quat(longint m11, m12, m13, m21, m22, m23,
                                         m31, m32, m33);
    longint cand[4];
    longint one, v, den;
    longint comp[4];
    int pick;
    quat_t r;
    one = longint'(1) <<< FRAC_BITS;
    cand[0] = m11 - m22 - m33 + one;
    cand[1] = -m11 + m22 - m33 + one;
    cand[2] = -m11 - m22 + m33 + one;
    cand[3] = m11 + m22 + m33 + one;
    pick = 0;
    for (int i = 1; i < 4; i++) if (cand[i] > cand[pick]) pick = i;
    v = longint'(int_sqrt(longint'(cand[pick]) <<< FRAC_BITS) >> 1);
    if (v == 0) v = 1;
    den = v * 4;
    r.sel = sel_t'(pick);
    case (r.sel)
      SEL_X: begin
        r.x = clamp(v);
        r.y = pair_quot(m12 + m21, den);
        r.z = pair_quot(m31 + m13, den);
        r.w = pair_quot(m23 - m32, den);
      end
      SEL_Y: begin
        r.y = clamp(v);
        r.x = pair_quot(m12 + m21, den);
        r.z = pair_quot(m23 + m32, den);
        r.w = pair_quot(m31 - m13, den);
      end
      SEL_Z: begin
        r.z = clamp(v);
        r.x = pair_quot(m31 + m13, den);
        r.y = pair_quot(m23 + m32, den);
        r.w = pair_quot(m12 - m21, den);
      end
      default: begin
        r.w = clamp(v);
        r.x = pair_quot(m23 - m32, den);
        r.y = pair_quot(m31 - m13, den);
        r.z = pair_quot(m12 - m21, den);
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    quat_t exp_q;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        quat_q.push_back(predict_quat(in_r1c1, in_r1c2, in_r1c3, in_r2c1, in_r2c2,
                                      in_r2c3, in_r3c1, in_r3c2, in_r3c3));
      end
      if (out_valid && out_ready) begin
        if (quat_q.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          exp_q = quat_q.pop_front();
          if (out_quat_x !== exp_q.x) report_mismatch("quat_x", out_quat_x, exp_q.x);
          if (out_quat_y !== exp_q.y) report_mismatch("quat_y", out_quat_y, exp_q.y);
          if (out_quat_z !== exp_q.z) report_mismatch("quat_z", out_quat_z, exp_q.z);
          if (out_quat_w !== exp_q.w) report_mismatch("quat_w", out_quat_w, exp_q.w);
          if (out_largest_sel !== exp_q.sel)
            report_mismatch("largest_sel", out_largest_sel, exp_q.sel);
        end
      end
    end
  end
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives directed and random matrices into the matrix to quaternion block
// with random idling on both sides and reports the verdict.
// ---------------------------------------------------------------------------
module tb_top;
  import rmq_pkg::*;

  localparam int ONE = 65536;
  localparam int RANDOM_ITEMS = 550;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [FIELD_W-1:0] m [9];
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [FIELD_W-1:0] out_quat_x, out_quat_y, out_quat_z, out_quat_w;
  sel_t out_largest_sel;
  int fail_count, pending;
  bit quiet = 1'b0;

  initial for (int i = 0; i < 9; i++) m[i] = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  rotation_matrix_to_quaternion DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_r1c1(m[0]), .in_r1c2(m[1]), .in_r1c3(m[2]),
    .in_r2c1(m[3]), .in_r2c2(m[4]), .in_r2c3(m[5]),
    .in_r3c1(m[6]), .in_r3c2(m[7]), .in_r3c3(m[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_quat_x(out_quat_x), .out_quat_y(out_quat_y), .out_quat_z(out_quat_z),
    .out_quat_w(out_quat_w), .out_largest_sel(out_largest_sel)
  );

  rmq_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_r1c1(m[0]), .in_r1c2(m[1]), .in_r1c3(m[2]),
    .in_r2c1(m[3]), .in_r2c2(m[4]), .in_r2c3(m[5]),
    .in_r3c1(m[6]), .in_r3c2(m[7]), .in_r3c3(m[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_quat_x(out_quat_x), .out_quat_y(out_quat_y), .out_quat_z(out_quat_z),
    .out_quat_w(out_quat_w), .out_largest_sel(out_largest_sel),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver stalls about 12 percent of the time, except in quiet stretches.
  always @(posedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 12);
  end

  function automatic logic signed [FIELD_W-1:0] rand_entry(int kind);
    case (kind)
      0: return FIELD_W'($urandom);
      1: return FIELD_W'($urandom_range(2 * ONE) - ONE);
      2: return ($urandom_range(1)) ? 18'sh1FFFF : 18'sh20000;
      default: return FIELD_W'($urandom_range(4000) - 2000);
    endcase
  endfunction

  // Presents one matrix and holds it until the beat is taken. Valid stays
  // high after the beat so that back-to-back beats need no gap.
  task automatic send(input logic signed [FIELD_W-1:0] e [9]);
    while (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    for (int i = 0; i < 9; i++) m[i] <= e[i];
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_diag(int a, int b, int c, int o);
    logic signed [FIELD_W-1:0] e [9];
    for (int i = 0; i < 9; i++) e[i] = FIELD_W'(o * (i + 1));
    e[0] = FIELD_W'(a); e[4] = FIELD_W'(b); e[8] = FIELD_W'(c);
    send(e);
  endtask

  initial begin
    logic signed [FIELD_W-1:0] e [9];
    int kind;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: identity, each axis winning, ties, extremes, non-rotations.
    send_diag(ONE, ONE, ONE, 0);
    send_diag(ONE, -ONE, -ONE, 100);
    send_diag(-ONE, ONE, -ONE, -300);
    send_diag(-ONE, -ONE, ONE, 777);
    send_diag(0, 0, 0, 0);
    send_diag(ONE, ONE, -ONE, 0);
    send_diag(-ONE, -ONE, -ONE, 0);
    send_diag(131071, 131071, 131071, 0);
    send_diag(-131072, -131072, -131072, 0);
    send_diag(131071, -131072, -131072, 131071);
    send_diag(-131072, 131071, -131072, -131072);
    send_diag(-131072, -131072, 131071, 131071);
    send_diag(-ONE, -ONE, -ONE, 131071);
    for (int i = 0; i < 9; i++) e[i] = 18'sh1FFFF;
    send(e);
    for (int i = 0; i < 9; i++) e[i] = 18'sh20000;
    send(e);
    for (int i = 0; i < 9; i++) e[i] = (i % 2) ? 18'sh20000 : 18'sh1FFFF;
    send(e);
    in_valid <= 1'b0;
    // Let the pipe drain before continuing.
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 200 && n < 280);
      kind = $urandom_range(3);
      for (int i = 0; i < 9; i++) e[i] = rand_entry(kind);
      send(e);
    end
    in_valid <= 1'b0;
    quiet = 1'b0;
    fork
      begin
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
      end
      begin
        repeat (200000) @(posedge clk);
      end
    join_any
    if (fail_count == 0 && pending == 0) begin
      $display("[rotation_matrix_to_quaternion] OK");
    end else begin
      $display("[rotation_matrix_to_quaternion] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[rotation_matrix_to_quaternion] ERROR");
    $finish;
  end
endmodule
